FILE: hdl/ibti_pkg.sv
// Shared types, sizes and op codes for the incomplete beta table interpolator.
`timescale 1ns / 1ps
`default_nettype none
package ibti_pkg;
    // grid points per curve and shape values per axis; memory sizes follow these, port widths do not
    localparam int MAX_POINTS = 64;
    localparam int MAX_SHAPES = 16;

    typedef enum logic [2:0] {
        OP_LOAD_GRID = 3'd0,
        OP_LOAD_FWD  = 3'd1,
        OP_LOAD_INV  = 3'd2,
        OP_QUERY_FWD = 3'd3,
        OP_QUERY_INV = 3'd4
    } t_op;
    localparam logic CFG_POINTS = 1'b0;
    localparam logic CFG_SHAPES = 1'b1;
endpackage
`default_nettype wire

FILE: hdl/incomplete_beta_table_interp.sv
// Top level: piecewise linear interpolation over a grid and two curve tables.
//
//  channel | signals                       | accepted when
//  --------+-------------------------------+--------------------------
//  request | i_valid/o_ready, op..point    | i_valid && o_ready
//  result  | o_valid/i_ready, answer flags | o_valid && i_ready
//  config  | i_cfg_we, i_cfg_index, data   | i_cfg_we
//
// Loads write their memory when accepted and leave the block idle. A query
// scans the grid from point 1 to the first point above the query point, or
// to point N-1 (N = points in use), with a read and a check state per point;
// it then reads the two table entries and sets up, runs a restoring divider
// for 2*(FRAC_BITS+1) quotient bits (one quotient bit per cycle, skipped on a
// zero grid step) and saturates the result. A bad shape answers the next
// cycle. One request at a time; a finished result sits in the output register
// and the next request is taken once it is delivered.
// Reset is synchronous, active low; memories are not cleared. Forward and
// inverse curves share one table memory, split by the top address bit.
`timescale 1ns / 1ps
`default_nettype none
module incomplete_beta_table_interp
    import ibti_pkg::*;
#(
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [0:0]           i_cfg_index,
    input  wire logic [6:0]           i_cfg_data,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [2:0]           i_op,
    input  wire logic [13:0]          i_entry_index,
    input  wire logic [FRAC_BITS:0]   i_entry_data,
    input  wire logic [4:0]           i_shape_p,
    input  wire logic [4:0]           i_shape_q,
    input  wire logic [FRAC_BITS:0]   i_query_point,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [FRAC_BITS:0]        o_answer,
    output logic                      o_clipped,
    output logic                      o_bad_shape
);
    localparam int VW     = FRAC_BITS + 1;
    localparam int DEPTH  = MAX_SHAPES * MAX_SHAPES * MAX_POINTS;
    localparam int AW     = $clog2(DEPTH);
    localparam int PW     = $clog2(MAX_POINTS);
    localparam int NW     = $clog2(MAX_POINTS + 1);
    localparam int SW     = $clog2(MAX_SHAPES + 1);
    // product dy*dx_offset magnitude width, and quotient width
    localparam int MW     = 2 * VW;
    localparam int QW     = MW;
    localparam int QCW    = $clog2(QW + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_LO_RD, S_HI_RD, S_TAB_WAIT, S_CALC,
        S_DIV, S_FIN, S_OUT
    } t_state;

    logic [VW-1:0] grid_mem [MAX_POINTS];
    logic [VW-1:0] tab_mem  [2*DEPTH];

    logic [6:0]    r_points;
    logic [4:0]    r_shapes;
    t_state        r_state;
    logic          r_tab_sel;
    logic [VW-1:0] r_x;
    logic [AW-1:0] r_base;
    logic [PW-1:0] r_i;
    logic [PW-1:0] r_grd_addr;
    logic [VW-1:0] r_grd_q;
    logic [AW-1:0] r_tab_addr;
    logic [VW-1:0] r_tab_q;
    logic [VW-1:0] r_xlo, r_xhi, r_ylo, r_yhi;
    logic          r_neg;
    logic [MW-1:0] r_rem;
    logic [MW-1:0] r_num;
    logic [VW-1:0] r_den;
    logic [QW-1:0] r_quo;
    logic [QCW-1:0] r_cnt;
    logic [VW-1:0] r_answer;
    logic          r_clipped, r_bad;

    // effective register values, clamped
    logic [NW-1:0] eff_n;
    logic [SW-1:0] eff_s;
    always_comb begin
        if (r_points < 7'd2) eff_n = NW'(2);
        else if (32'(r_points) > MAX_POINTS) eff_n = NW'(MAX_POINTS);
        else eff_n = NW'(r_points);
        if (r_shapes < 5'd1) eff_s = SW'(1);
        else if (32'(r_shapes) > MAX_SHAPES) eff_s = SW'(MAX_SHAPES);
        else eff_s = SW'(r_shapes);
    end

    logic accept;
    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;
    assign o_valid = (r_state == S_OUT);
    assign o_answer    = r_answer;
    assign o_clipped   = r_clipped;
    assign o_bad_shape = r_bad;

    // memory writes (loads) and registered reads
    always_ff @(posedge i_clk) begin
        if (accept && i_op == OP_LOAD_GRID && 32'(i_entry_index) < MAX_POINTS)
            grid_mem[i_entry_index[PW-1:0]] <= i_entry_data;
        r_grd_q <= grid_mem[r_grd_addr];
    end
    always_ff @(posedge i_clk) begin
        if (accept && (i_op == OP_LOAD_FWD || i_op == OP_LOAD_INV)
                && 32'(i_entry_index) < DEPTH)
            tab_mem[{i_op == OP_LOAD_INV, i_entry_index[AW-1:0]}] <= i_entry_data;
        r_tab_q <= tab_mem[{r_tab_sel, r_tab_addr}];
    end

    // interpolation arithmetic, spread over S_CALC
    logic signed [VW+1:0] dy, dxo, dx;
    logic [VW:0]          udy, udxo, udx;
    logic [MW-1:0]        prod;
    always_comb begin
        dy   = $signed({2'b00, r_yhi}) - $signed({2'b00, r_ylo});
        dxo  = $signed({2'b00, r_x}) - $signed({2'b00, r_xhi});
        dx   = $signed({2'b00, r_xhi}) - $signed({2'b00, r_xlo});
        udy  = dy[VW+1] ? (VW+1)'(-dy) : dy[VW:0];
        udxo = dxo[VW+1] ? (VW+1)'(-dxo) : dxo[VW:0];
        udx  = dx[VW+1] ? (VW+1)'(-dx) : dx[VW:0];
        prod = MW'(udy) * MW'(udxo);
    end

    logic [MW:0]   trial;
    assign trial = {r_rem, r_num[MW-1]} - {{(MW+1-VW){1'b0}}, r_den};

    // final sum: yhi +/- quotient, saturated
    logic signed [QW+1:0] sval;
    always_comb begin
        sval = r_neg ? $signed({2'b00, {(QW-VW){1'b0}}, r_yhi}) - $signed({2'b00, r_quo})
                     : $signed({2'b00, {(QW-VW){1'b0}}, r_yhi}) + $signed({2'b00, r_quo});
    end

    logic [PW:0] i_ext;
    assign i_ext = {1'b0, r_i};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_points <= 7'd64;
            r_shapes <= 5'd16;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_POINTS: r_points <= i_cfg_data;
                    CFG_SHAPES: r_shapes <= i_cfg_data[4:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept && (i_op == OP_QUERY_FWD || i_op == OP_QUERY_INV)) begin
                        r_tab_sel <= (i_op == OP_QUERY_INV);
                        r_x       <= i_query_point;
                        if (i_shape_p == 5'd0 || i_shape_q == 5'd0 ||
                            SW'(i_shape_p) > eff_s || SW'(i_shape_q) > eff_s ||
                            i_shape_p > 5'(MAX_SHAPES) || i_shape_q > 5'(MAX_SHAPES)) begin
                            r_answer  <= '0;
                            r_clipped <= 1'b0;
                            r_bad     <= 1'b1;
                            r_state   <= S_OUT;
                        end else begin
                            r_base <= AW'((AW'(i_shape_q - 5'd1) * AW'(eff_s)
                                          + AW'(i_shape_p - 5'd1)) * AW'(eff_n));
                            r_i        <= PW'(1);
                            r_grd_addr <= PW'(1);
                            r_bad      <= 1'b0;
                            r_state    <= S_SCAN_RD;
                        end
                    end
                end
                // wait for the registered grid read
                S_SCAN_RD: r_state <= S_SCAN_CHK;
                S_SCAN_CHK: begin
                    if (r_grd_q > r_x || NW'(i_ext) + NW'(1) >= eff_n) begin
                        r_xhi      <= r_grd_q;
                        r_grd_addr <= r_i - PW'(1);
                        r_tab_addr <= r_base + AW'(r_i) - AW'(1);
                        r_state    <= S_LO_RD;
                    end else begin
                        r_i        <= r_i + PW'(1);
                        r_grd_addr <= r_i + PW'(1);
                        r_state    <= S_SCAN_RD;
                    end
                end
                S_LO_RD: begin
                    r_tab_addr <= r_base + AW'(r_i);
                    r_state    <= S_HI_RD;
                end
                S_HI_RD: begin
                    r_xlo   <= r_grd_q;
                    r_ylo   <= r_tab_q;
                    r_state <= S_TAB_WAIT;
                end
                S_TAB_WAIT: begin
                    r_yhi   <= r_tab_q;
                    r_state <= S_CALC;
                end
                S_CALC: begin
                    // round half away: (|num| + |den|/2) / |den|, sign applied after
                    r_neg   <= dy[VW+1] ^ dxo[VW+1] ^ dx[VW+1];
                    r_den   <= udx[VW-1:0];
                    r_num   <= prod + MW'(udx >> 1);
                    r_rem   <= '0;
                    r_quo   <= '0;
                    r_cnt   <= QCW'(QW);
                    r_state <= (r_xhi == r_xlo) ? S_FIN : S_DIV;
                end
                S_DIV: begin
                    if (!trial[MW]) begin
                        r_rem <= trial[MW-1:0];
                        r_quo <= {r_quo[QW-2:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[MW-2:0], r_num[MW-1]};
                        r_quo <= {r_quo[QW-2:0], 1'b0};
                    end
                    r_num <= {r_num[MW-2:0], 1'b0};
                    r_cnt <= r_cnt - QCW'(1);
                    if (r_cnt == QCW'(1)) r_state <= S_FIN;
                end
                S_FIN: begin
                    if (sval < 0) begin
                        r_answer  <= '0;
                        r_clipped <= 1'b1;
                    end else if (sval > $signed((QW+2)'(1) <<< FRAC_BITS)) begin
                        r_answer  <= VW'(1) << FRAC_BITS;
                        r_clipped <= 1'b1;
                    end else begin
                        r_answer  <= sval[VW-1:0];
                        r_clipped <= 1'b0;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: if (i_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: test/tb.sv
// Testbench for the piecewise linear table interpolator: loads, queries, config sweeps.
`timescale 1ns / 1ps
module tb
    import ibti_pkg::*;
();

    localparam int NPTS       = 64;
    localparam int NSHP       = 16;
    localparam int DEPTH      = NSHP * NSHP * NPTS;
    localparam int ONE        = 1 << 16;
    localparam int SETTLE     = 200;      // longer than the worst query
    localparam longint LIMIT  = 4000000;
    // op codes the block has no use for; they must be dropped silently
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [16:0] answer;
        logic        clipped;
        logic        bad_shape;
    } t_answer;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [0:0]  i_cfg_index = '0;
    logic [6:0]  i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [2:0]  i_op = '0;
    logic [13:0] i_entry_index = '0;
    logic [16:0] i_entry_data = '0;
    logic [4:0]  i_shape_p = '0;
    logic [4:0]  i_shape_q = '0;
    logic [16:0] i_query_point = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [16:0] o_answer;
    logic        o_clipped;
    logic        o_bad_shape;

    incomplete_beta_table_interp dut (.*);

    always #6 i_clk = ~i_clk;

    // shadow state of the block
    logic [16:0] grid_shadow [NPTS];
    logic [16:0] fwd_shadow  [DEPTH];
    logic [16:0] inv_shadow  [DEPTH];
    bit          fwd_loaded  [DEPTH];
    bit          inv_loaded  [DEPTH];
    int          points_reg = 64;
    int          shapes_reg = 16;

    t_answer     pending_answers [$];
    int          mismatches = 0;
    int          items_sent = 0;
    int          sender_idle_pct = 0;
    int          receiver_stall_pct = 0;
    int          hold_off_cycles = 0;
    longint      cycle_count = 0;

    function automatic int points_eff();
        return points_reg < 2 ? 2 : (points_reg > NPTS ? NPTS : points_reg);
    endfunction

    function automatic int shapes_eff();
        return shapes_reg < 1 ? 1 : (shapes_reg > NSHP ? NSHP : shapes_reg);
    endfunction

    function automatic bit shape_ok(int p, int q);
        return p != 0 && q != 0 && p <= shapes_eff() && q <= shapes_eff();
    endfunction

    // first grid point above x, limited to the last segment
    function automatic int segment_of(int x);
        int n;
        int i;
        n = points_eff();
        for (i = 1; i < n - 1; i++)
            if (int'(grid_shadow[i]) > x) break;
        return i;
    endfunction

    function automatic int curve_base(int p, int q);
        return ((q - 1) * shapes_eff() + (p - 1)) * points_eff();
    endfunction

    // divide rounding to nearest, ties away from zero
    function automatic longint div_nearest(longint num, longint den);
        longint un;
        longint ud;
        longint qt;
        un = num < 0 ? -num : num;
        ud = den < 0 ? -den : den;
        qt = (un + ud / 2) / ud;
        return ((num < 0) != (den < 0)) ? -qt : qt;
    endfunction

    function automatic t_answer interp_answer(bit inverse, int p, int q, int x);
        t_answer r;
        int      i;
        int      b;
        longint  xlo, xhi, ylo, yhi, v;
        r = '0;
        if (!shape_ok(p, q)) begin
            r.bad_shape = 1'b1;
            return r;
        end
        i   = segment_of(x);
        b   = curve_base(p, q);
        xlo = grid_shadow[i - 1];
        xhi = grid_shadow[i];
        ylo = inverse ? inv_shadow[b + i - 1] : fwd_shadow[b + i - 1];
        yhi = inverse ? inv_shadow[b + i] : fwd_shadow[b + i];
        if (xhi == xlo) v = yhi;
        else v = yhi + div_nearest((yhi - ylo) * (longint'(x) - xhi), xhi - xlo);
        if (v < 0) begin
            r.clipped = 1'b1;
        end else if (v > ONE) begin
            r.answer  = 17'(ONE);
            r.clipped = 1'b1;
        end else begin
            r.answer = 17'(v);
        end
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Request side: drive one request, hold it until taken, then apply
    // it to the shadow state and queue the expected answer.
    // ---------------------------------------------------------------
    task automatic send_request(logic [2:0] op, int idx, int data, int p, int q, int x);
        @(negedge i_clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid       = 1'b1;
        i_op          = op;
        i_entry_index = 14'(idx);
        i_entry_data  = 17'(data);
        i_shape_p     = 5'(p);
        i_shape_q     = 5'(q);
        i_query_point = 17'(x);
        do @(posedge i_clk); while (!o_ready);
        items_sent++;
        case (op)
            OP_LOAD_GRID: if (idx < NPTS) grid_shadow[idx] = 17'(data);
            OP_LOAD_FWD: begin
                fwd_shadow[idx] = 17'(data);
                fwd_loaded[idx] = 1'b1;
            end
            OP_LOAD_INV: begin
                inv_shadow[idx] = 17'(data);
                inv_loaded[idx] = 1'b1;
            end
            OP_QUERY_FWD: pending_answers.push_back(interp_answer(1'b0, p, q, x));
            OP_QUERY_INV: pending_answers.push_back(interp_answer(1'b1, p, q, x));
            default: ;
        endcase
    endtask

    task automatic idle_sender();
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    // Query, first loading any table entry the segment will read that was
    // never written.
    task automatic query(bit inverse, int p, int q, int x);
        int i;
        int b;
        x = x & 17'h1FFFF;
        if (shape_ok(p, q)) begin
            i = segment_of(x);
            b = curve_base(p, q);
            for (int k = b + i - 1; k <= b + i; k++) begin
                if (inverse && !inv_loaded[k])
                    send_request(OP_LOAD_INV, k, $urandom_range(ONE), 0, 0, 0);
                if (!inverse && !fwd_loaded[k])
                    send_request(OP_LOAD_FWD, k, $urandom_range(ONE), 0, 0, 0);
            end
        end
        send_request(inverse ? OP_QUERY_INV : OP_QUERY_FWD, 0, 0, p, q, x);
    endtask

    // Fill the whole grid. Mostly rising; the rough kind mixes in repeated
    // points (zero step) and backward steps.
    task automatic load_grid(bit rough);
        int g;
        int step;
        g = $urandom_range(2000);
        for (int k = 0; k < NPTS; k++) begin
            send_request(OP_LOAD_GRID, k, g, 0, 0, 0);
            step = $urandom_range(2 * ONE / NPTS);
            if (rough && $urandom_range(5) == 0) step = 0;
            if (rough && $urandom_range(9) == 0) step = -int'($urandom_range(3000));
            g = g + step;
            if (g < 0) g = 0;
            if (g > 17'h1FFFF) g = 17'h1FFFF;
        end
    endtask

    // Block idle: drop valid, nothing pending and any load finished.
    task automatic drain();
        @(negedge i_clk);
        i_valid = 1'b0;
        wait (pending_answers.size() == 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_register(logic [0:0] index, int value);
        drain();
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = index;
        i_cfg_data  = 7'(value);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (index == CFG_POINTS) points_reg = value & 7'h7F;
        else shapes_reg = value & 5'h1F;
    endtask

    // random query point: mostly within 200 of the grid span, sometimes anywhere
    function automatic int pick_point();
        int lo;
        int hi;
        lo = grid_shadow[0];
        hi = grid_shadow[points_eff() - 1];
        if ($urandom_range(4) == 0 || hi <= lo) return $urandom_range(17'h1FFFF);
        return $urandom_range(hi + 200, lo > 200 ? lo - 200 : 0);
    endfunction

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_directed();
        int s;
        load_grid(1'b0);
        s = shapes_eff();
        query(1'b0, 1, 1, 0);
        query(1'b1, 1, 1, 17'h1FFFF);
        query(1'b0, s, s, grid_shadow[5]);
        query(1'b1, s, 1, grid_shadow[NPTS - 1] + 1);
        // out-of-range values in the first segment of one table, then queries at both ends
        send_request(OP_LOAD_FWD, curve_base(2, 3) + 1, 17'h1FFFF, 0, 0, 0);
        send_request(OP_LOAD_FWD, curve_base(2, 3), 0, 0, 0, 0);
        query(1'b0, 2, 3, 17'h1FFFF);
        query(1'b0, 2, 3, 0);
        // bad shapes: zero, above shapes in use, all bits set
        query(1'b0, 0, 1, 100);
        query(1'b1, 1, 0, 100);
        query(1'b0, s + 1, 1, 100);
        query(1'b1, 31, 31, 100);
        // spare op codes and a grid load past the grid are dropped
        for (logic [3:0] op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++)
            send_request(op[2:0], 16383, 17'h1FFFF, 31, 31, 17'h1FFFF);
        send_request(OP_LOAD_GRID, 16383, 5, 0, 0, 0);
        // zero grid step on the first segment
        send_request(OP_LOAD_GRID, 0, 1000, 0, 0, 0);
        send_request(OP_LOAD_GRID, 1, 1000, 0, 0, 0);
        query(1'b0, 1, 2, 5);
        query(1'b1, 1, 2, 5);
        load_grid(1'b0);
    endtask

    task automatic test_config_extremes();
        int pts [6] = '{2, 64, 0, 1, 100, 127};
        int shp [5] = '{1, 16, 0, 31, 7};
        for (int k = 0; k < 6; k++) begin
            write_register(CFG_POINTS, pts[k]);
            write_register(CFG_SHAPES, shp[k % 5]);
            repeat (4) query(1'($urandom_range(1)), $urandom_range(1, shapes_eff() + 1),
                             $urandom_range(1, shapes_eff()), pick_point());
        end
    endtask

    task automatic test_random(int items);
        int pts_pick [4] = '{64, 2, 17, 40};
        int shp_pick [4] = '{16, 1, 5, 11};
        int idle_pct [4] = '{0, 66, 0, 11};
        int stall_pct [4] = '{0, 0, 66, 11};
        int stop;
        int sel;
        int p;
        int q;
        for (int phase = 0; phase < 4; phase++) begin
            write_register(CFG_POINTS, $urandom_range(1) ? pts_pick[phase]
                                                          : $urandom_range(127));
            write_register(CFG_SHAPES, $urandom_range(1) ? shp_pick[phase]
                                                          : $urandom_range(31));
            sender_idle_pct    = idle_pct[phase];
            receiver_stall_pct = stall_pct[phase];
            if (phase == 2) load_grid(1'b1);
            stop = items_sent + items / 4;
            while (items_sent < stop) begin
                sel = $urandom_range(99);
                if ($urandom_range(7) == 0) begin
                    // stretch with no idling at all
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end else begin
                    sender_idle_pct    = idle_pct[phase];
                    receiver_stall_pct = stall_pct[phase];
                end
                if (sel < 65) begin
                    p = $urandom_range(1, shapes_eff());
                    q = $urandom_range(1, shapes_eff());
                    if ($urandom_range(19) == 0) p = $urandom_range(31);
                    query(1'($urandom_range(1)), p, q, pick_point());
                end else if (sel < 92) begin
                    send_request($urandom_range(1) ? OP_LOAD_FWD : OP_LOAD_INV,
                                 $urandom_range(16383), $urandom_range(17'h1FFFF), 0, 0, 0);
                end else if (sel < 96) begin
                    send_request(OP_LOAD_GRID, $urandom_range(NPTS - 1),
                                 $urandom_range(17'h1FFFF), 0, 0, 0);
                end else begin
                    // dropped requests
                    send_request(3'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST)),
                                 $urandom_range(16383), $urandom_range(17'h1FFFF),
                                 $urandom_range(31), $urandom_range(31),
                                 $urandom_range(17'h1FFFF));
                end
            end
        end
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
    endtask

    // Hold the result side off long enough that the block fills and
    // stalls its request side, then pause until everything has drained and query again.
    task automatic test_back_pressure();
        hold_off_cycles = 800;
        repeat (8) query(1'($urandom_range(1)), $urandom_range(1, shapes_eff()),
                         $urandom_range(1, shapes_eff()), pick_point());
        idle_sender();
        wait (pending_answers.size() == 0);
        repeat (6) query(1'($urandom_range(1)), $urandom_range(1, shapes_eff()),
                         $urandom_range(1, shapes_eff()), pick_point());
    endtask

    // ---------------------------------------------------------------
    // Result side
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_off_cycles > 0) begin
            i_ready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end else begin
            i_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // compare each delivered answer with the oldest one predicted
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_answers.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected answer %0d clipped %0d bad_shape %0d",
                             o_answer, o_clipped, o_bad_shape);
            end else begin
                want = pending_answers.pop_front();
                if (o_answer !== want.answer || o_clipped !== want.clipped
                        || o_bad_shape !== want.bad_shape) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("answer mismatch: want %0d/%0d/%0d got %0d/%0d/%0d",
                                 want.answer, want.clipped, want.bad_shape,
                                 o_answer, o_clipped, o_bad_shape);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("[incomplete_beta_table_interp] ERROR");
            $finish;
        end
    end

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_config_extremes();
        write_register(CFG_POINTS, 64);
        write_register(CFG_SHAPES, 16);
        test_back_pressure();
        test_random(1300);
        idle_sender();
        drain();
        if (mismatches + pending_answers.size() == 0) begin
            $display("[incomplete_beta_table_interp] OK");
        end else begin
            $display("[incomplete_beta_table_interp] ERROR");
        end
        $finish;
    end
endmodule

FILE: sim.f
hdl/ibti_pkg.sv
hdl/incomplete_beta_table_interp.sv
test/tb.sv
